### src/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared types and constants of the GIF frame counter: block markers,
// parser phase codes, status codes and the result word.
// ----------------------------------------------------------------------------
package gfc_pkg;

    // Block markers and header constants.
    localparam logic [7:0] MK_TRAILER = 8'h3b;
    localparam logic [7:0] MK_IMAGE   = 8'h2c;
    localparam logic [7:0] MK_EXT     = 8'h21;
    localparam logic [7:0] TABLE_FLAG = 8'h80;
    localparam logic [7:0] TABLE_BITS = 8'h07;
    localparam logic [9:0] HEADER_LEN = 10'd13;
    localparam logic [9:0] HEADER_PACKED_POS = 10'd10;
    localparam logic [9:0] DESC_LEN   = 10'd9;

    localparam logic [7:0] SIG_0 = 8'h47;
    localparam logic [7:0] SIG_1 = 8'h49;
    localparam logic [7:0] SIG_2 = 8'h46;

    // Parser phases.
    localparam logic [3:0] PH_HDR  = 4'd0;
    localparam logic [3:0] PH_GCT  = 4'd1;
    localparam logic [3:0] PH_MARK = 4'd2;
    localparam logic [3:0] PH_DESC = 4'd3;
    localparam logic [3:0] PH_LCT  = 4'd4;
    localparam logic [3:0] PH_CODE = 4'd5;
    localparam logic [3:0] PH_ILEN = 4'd6;
    localparam logic [3:0] PH_IDAT = 4'd7;
    localparam logic [3:0] PH_XLAB = 4'd8;
    localparam logic [3:0] PH_XLEN = 4'd9;
    localparam logic [3:0] PH_XDAT = 4'd10;
    localparam logic [3:0] PH_DONE = 4'd11;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [15:0] image_count;
        logic [15:0] resolved_start;
        logic [1:0]  status;
    } result_t;

    // Expected signature byte at header position 0 to 2.
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = SIG_0;
            2'd1:    b = SIG_1;
            default: b = SIG_2;
        endcase
        return b;
    endfunction

    // Size in bytes of a color table: (2 << size bits) * 3.
    function automatic logic [9:0] table_bytes(input logic [7:0] packed_byte);
        logic [9:0] entries;
        entries = 10'd2 << (packed_byte & TABLE_BITS);
        return entries + (entries << 1);
    endfunction

endpackage

### src/gfc_parser.sv
// ----------------------------------------------------------------------------
// gfc_parser
// Block structure walker. Holds the parse state and advances it by one
// file byte per step; reports the end-of-file verdict and frame count.
// ----------------------------------------------------------------------------
module gfc_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  is_last,
    output logic                  fin_bad,
    output logic [COUNT_BITS-1:0] fin_count
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [3:0]            phase_reg,    phase_next;
    logic [9:0]            skip_reg,     skip_next;
    logic [7:0]            flags_reg,    flags_next;
    logic [COUNT_BITS-1:0] frames_reg,   frames_next;
    logic                  finished_reg, finished_next;
    logic                  error_reg,    error_next;

    always_comb
    begin
        logic [9:0] skip_inc;
        logic [9:0] skip_dec;
        logic [7:0] flags_hdr;
        logic [7:0] flags_desc;

        phase_next    = phase_reg;
        skip_next     = skip_reg;
        flags_next    = flags_reg;
        frames_next   = frames_reg;
        finished_next = finished_reg;
        error_next    = error_reg;

        skip_inc   = skip_reg + 10'd1;
        skip_dec   = (skip_reg != 10'd0) ? skip_reg - 10'd1 : skip_reg;
        flags_hdr  = (skip_reg == gfc_pkg::HEADER_PACKED_POS) ? data_byte : flags_reg;
        flags_desc = (skip_reg == gfc_pkg::DESC_LEN - 10'd1) ? data_byte : flags_reg;

        if (!error_reg && !finished_reg)
        begin
            unique case (phase_reg)
                gfc_pkg::PH_HDR:
                begin
                    if (skip_reg < 10'd3 && data_byte != gfc_pkg::sig_byte(skip_reg[1:0]))
                    begin
                        error_next = 1'b1;
                    end
                    flags_next = flags_hdr;
                    skip_next  = skip_inc;
                    if (skip_inc >= gfc_pkg::HEADER_LEN)
                    begin
                        if ((flags_hdr & gfc_pkg::TABLE_FLAG) != 8'd0)
                        begin
                            skip_next  = gfc_pkg::table_bytes(flags_hdr);
                            phase_next = gfc_pkg::PH_GCT;
                        end
                        else
                        begin
                            skip_next  = 10'd0;
                            phase_next = gfc_pkg::PH_MARK;
                        end
                    end
                end
                gfc_pkg::PH_GCT, gfc_pkg::PH_LCT:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 10'd0)
                    begin
                        phase_next = (phase_reg == gfc_pkg::PH_GCT) ? gfc_pkg::PH_MARK
                                                                    : gfc_pkg::PH_CODE;
                    end
                end
                gfc_pkg::PH_MARK:
                begin
                    priority if (data_byte == gfc_pkg::MK_TRAILER)
                    begin
                        finished_next = 1'b1;
                        phase_next    = gfc_pkg::PH_DONE;
                    end
                    else if (data_byte == gfc_pkg::MK_IMAGE)
                    begin
                        skip_next  = 10'd0;
                        phase_next = gfc_pkg::PH_DESC;
                    end
                    else if (data_byte == gfc_pkg::MK_EXT)
                    begin
                        phase_next = gfc_pkg::PH_XLAB;
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
                gfc_pkg::PH_DESC:
                begin
                    flags_next = flags_desc;
                    skip_next  = skip_inc;
                    if (skip_inc >= gfc_pkg::DESC_LEN)
                    begin
                        if ((flags_desc & gfc_pkg::TABLE_FLAG) != 8'd0)
                        begin
                            skip_next  = gfc_pkg::table_bytes(flags_desc);
                            phase_next = gfc_pkg::PH_LCT;
                        end
                        else
                        begin
                            skip_next  = 10'd0;
                            phase_next = gfc_pkg::PH_CODE;
                        end
                    end
                end
                gfc_pkg::PH_CODE:
                begin
                    phase_next = gfc_pkg::PH_ILEN;
                end
                gfc_pkg::PH_ILEN, gfc_pkg::PH_XLEN:
                begin
                    if (data_byte == 8'd0)
                    begin
                        // A zero-length sub-block closes an image or an extension; only an image is counted.
                        if (phase_reg == gfc_pkg::PH_ILEN && frames_reg != CNT_MAX)
                        begin
                            frames_next = frames_reg + 1'b1;
                        end
                        phase_next = gfc_pkg::PH_MARK;
                    end
                    else
                    begin
                        skip_next  = {2'b00, data_byte};
                        phase_next = (phase_reg == gfc_pkg::PH_ILEN) ? gfc_pkg::PH_IDAT
                                                                     : gfc_pkg::PH_XDAT;
                    end
                end
                gfc_pkg::PH_IDAT, gfc_pkg::PH_XDAT:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 10'd0)
                    begin
                        phase_next = (phase_reg == gfc_pkg::PH_IDAT) ? gfc_pkg::PH_ILEN
                                                                     : gfc_pkg::PH_XLEN;
                    end
                end
                gfc_pkg::PH_XLAB:
                begin
                    phase_next = gfc_pkg::PH_XLEN;
                end
                default:
                begin
                    finished_next = 1'b1;
                    phase_next    = gfc_pkg::PH_DONE;
                end
            endcase
        end
    end

    assign fin_bad = error_next ||
                     (phase_next != gfc_pkg::PH_MARK && phase_next != gfc_pkg::PH_DONE);
    assign fin_count = frames_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= gfc_pkg::PH_HDR;
            skip_reg     <= 10'd0;
            flags_reg    <= 8'd0;
            frames_reg   <= '0;
            finished_reg <= 1'b0;
            error_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (is_last)
            begin
                // The last byte closes the file; the next byte starts a new one.
                phase_reg    <= gfc_pkg::PH_HDR;
                skip_reg     <= 10'd0;
                flags_reg    <= 8'd0;
                frames_reg   <= '0;
                finished_reg <= 1'b0;
                error_reg    <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                skip_reg     <= skip_next;
                flags_reg    <= flags_next;
                frames_reg   <= frames_next;
                finished_reg <= finished_next;
                error_reg    <= error_next;
            end
        end
    end

endmodule

### src/gfc_result.sv
// ----------------------------------------------------------------------------
// gfc_result
// Start frame resolution and the result register toward the output channel.
// ----------------------------------------------------------------------------
module gfc_result #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  out_stall,
    input  logic signed [15:0]    start_frame,
    input  logic                  fin_bad,
    input  logic [COUNT_BITS-1:0] fin_count,
    output logic                  out_valid,
    output gfc_pkg::result_t      res
);

    logic             out_valid_reg;
    gfc_pkg::result_t res_reg, res_next;

    logic [32:0]        cnt_w;
    logic signed [33:0] cnt_s;
    logic signed [33:0] req_s;
    logic signed [33:0] idx_s;

    always_comb
    begin
        cnt_w = 33'(fin_count);
        cnt_s = $signed({1'b0, cnt_w});
        req_s = 34'(start_frame);
        // A negative request counts back from the frame count.
        idx_s = req_s[33] ? cnt_s + req_s : req_s;

        res_next.image_count    = (cnt_w > 33'd65535) ? 16'hffff : cnt_w[15:0];
        res_next.resolved_start = 16'd0;
        priority if (fin_bad || cnt_w == 33'd0)
        begin
            res_next.status = gfc_pkg::STATUS_BAD;
        end
        else if (idx_s[33] || idx_s >= cnt_s)
        begin
            res_next.status = gfc_pkg::STATUS_RANGE;
        end
        else
        begin
            res_next.status         = gfc_pkg::STATUS_OK;
            res_next.resolved_start = idx_s[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

### src/gif_frame_counter_top.sv
// ----------------------------------------------------------------------------
// gif_frame_counter_top
// Counts the images of a GIF file streamed one byte per word and resolves
// the requested start frame against that count at the last byte.
// ----------------------------------------------------------------------------
// The result word of a last byte is registered: the byte passes the input
// register, then its parser step loads the result register.
// Throughput: one byte per cycle; the input register and the parser step
// every cycle unless a last byte waits on a stalled, occupied result register.
// Reset clears the parse state, the start frame register and both valids.
// After each last byte the parse state returns to its reset values.
module gif_frame_counter_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start_frame_we,
    input  logic signed [15:0] start_frame,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        image_count,
    output logic [15:0]        resolved_start,
    output logic [1:0]         status
);

    logic signed [15:0] start_frame_reg;
    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic               advance;
    logic               step;
    logic               fin_bad;
    logic [COUNT_BITS-1:0] fin_count;
    gfc_pkg::result_t   res;

    // Only a last byte needs room in the result register.
    assign advance  = !last_reg || !out_valid || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_frame_reg <= 16'sd0;
        end
        else if (start_frame_we)
        begin
            start_frame_reg <= start_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= data_byte;
            last_reg <= is_last;
        end
    end

    gfc_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_reg),
        .is_last   (last_reg),
        .fin_bad   (fin_bad),
        .fin_count (fin_count)
    );

    gfc_result #(
        .COUNT_BITS (COUNT_BITS)
    ) u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && last_reg),
        .out_stall   (out_stall),
        .start_frame (start_frame_reg),
        .fin_bad     (fin_bad),
        .fin_count   (fin_count),
        .out_valid   (out_valid),
        .res         (res)
    );

    assign image_count    = res.image_count;
    assign resolved_start = res.resolved_start;
    assign status         = res.status;

endmodule

### src/gfc_checker.sv
// ----------------------------------------------------------------------------
// gfc_checker
// Port-level checks of the GIF frame counter, bound to the top level.
// ----------------------------------------------------------------------------
module gfc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               is_last,
    input logic               out_valid,
    input logic               out_stall,
    input logic [15:0]        image_count,
    input logic [15:0]        resolved_start,
    input logic [1:0]         status
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(image_count) &&
                                   $stable(resolved_start) && $stable(status))
        else $error("stalled result word changed");

    // A result word that turns valid follows an accepted last byte.
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && is_last, 2))
        else $error("result word without a last byte");

    // Failed resolutions report a zero start frame.
    a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != gfc_pkg::STATUS_OK |-> resolved_start == 16'd0)
        else $error("nonzero start frame on a failed status");

    // The status code is a known one, and an ok status needs at least one frame.
    a_ok_frames: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == gfc_pkg::STATUS_BAD || status == gfc_pkg::STATUS_RANGE ||
                       (status == gfc_pkg::STATUS_OK && image_count != 16'd0)))
        else $error("bad status code or ok status with no frames");

endmodule

bind gif_frame_counter_top gfc_checker u_gfc_checker (.*);
